// ===== rtl/pi_d_controller_tustin_top_assert.svh =====
// Assertion macros shared by the checker of the PI-D controller.
`ifndef PI_D_CONTROLLER_TUSTIN_TOP_ASSERT_SVH
`define PI_D_CONTROLLER_TUSTIN_TOP_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define PIDT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PIDT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pidt_pkg.sv =====
// Types, constants, microprogram and saturating helpers of the PI-D controller.
package pidt_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	// pi/180 as unsigned Q0.32, rounded at bit 32 regardless of the data format.
	localparam int DEG_SHIFT  = 32;
	localparam int DEG_W      = 28;
	localparam int MUL_W      = (DATA_WIDTH > DEG_W) ? DATA_WIDTH : DEG_W;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int ACC_W      = DATA_WIDTH + 2;
	localparam int STEP_W     = 4;
	localparam int CFG_IDX_W  = 3;

	localparam logic signed [MUL_W-1:0] DEG_TO_RAD = MUL_W'(74961321);

	localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_MAX =
		{{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN =
		{{(ACC_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [PROD_W:0] PW_MAX =
		{{(PROD_W-DATA_WIDTH+2){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [PROD_W:0] PW_MIN =
		{{(PROD_W-DATA_WIDTH+2){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [PROD_W:0] RND_FRAC =
		{{(PROD_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic signed [PROD_W:0] RND_DEG =
		{{(PROD_W+1-DEG_SHIFT){1'b0}}, 1'b1, {(DEG_SHIFT-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_INTEGRAL_STEP,
		REG_DERIV_INPUT_COEF,
		REG_DERIV_FEEDBACK_COEF,
		REG_ANGLE_MODE,
		REG_WINDUP_MODE
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ALU_NOP,
		ALU_DIFF,
		ALU_E_RND,
		ALU_ESUM,
		ALU_ACC_P,
		ALU_INTEG,
		ALU_DTMP,
		ALU_DERIV,
		ALU_ACC_I,
		ALU_FINISH
	} alu_op_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_E_DEG,
		MUL_GP_E,
		MUL_IS_ESUM,
		MUL_DCIN_DM,
		MUL_DFB_D,
		MUL_GI_I,
		MUL_GD_D
	} mul_sel_t;

	typedef struct packed {
		alu_op_t             alu;
		mul_sel_t            mul;
		logic                rnd_en;
		logic                rnd_wide;
		logic                br_nangle;
		logic [STEP_W-1:0]   target;
		logic                last;
	} uword_t;

	localparam logic [STEP_W-1:0] ST_DIFF    = STEP_W'(0);
	localparam logic [STEP_W-1:0] ST_ANGLE   = STEP_W'(1);
	localparam logic [STEP_W-1:0] ST_ANG_RND = STEP_W'(2);
	localparam logic [STEP_W-1:0] ST_ANG_E   = STEP_W'(3);
	localparam logic [STEP_W-1:0] ST_ESUM    = STEP_W'(4);
	localparam logic [STEP_W-1:0] ST_MUL_IS  = STEP_W'(5);
	localparam logic [STEP_W-1:0] ST_ACC_P   = STEP_W'(6);
	localparam logic [STEP_W-1:0] ST_INTEG   = STEP_W'(7);
	localparam logic [STEP_W-1:0] ST_DTMP    = STEP_W'(8);
	localparam logic [STEP_W-1:0] ST_DERIV   = STEP_W'(9);
	localparam logic [STEP_W-1:0] ST_ACC_I   = STEP_W'(10);
	localparam logic [STEP_W-1:0] ST_RND_D   = STEP_W'(11);
	localparam logic [STEP_W-1:0] ST_FINISH  = STEP_W'(12);

	// The rounding unit always works on the product started one step earlier.
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t uw;
		uw = '{alu: ALU_NOP, mul: MUL_NONE, rnd_en: 1'b0, rnd_wide: 1'b0,
			br_nangle: 1'b0, target: ST_DIFF, last: 1'b0};
		unique case (step)
			ST_DIFF:    uw.alu = ALU_DIFF;
			ST_ANGLE: begin
				uw.mul       = MUL_E_DEG;
				uw.br_nangle = 1'b1;
				uw.target    = ST_ESUM;
			end
			ST_ANG_RND: begin
				uw.rnd_en   = 1'b1;
				uw.rnd_wide = 1'b1;
			end
			ST_ANG_E:   uw.alu = ALU_E_RND;
			ST_ESUM: begin
				uw.alu = ALU_ESUM;
				uw.mul = MUL_GP_E;
			end
			ST_MUL_IS: begin
				uw.mul    = MUL_IS_ESUM;
				uw.rnd_en = 1'b1;
			end
			ST_ACC_P: begin
				uw.alu    = ALU_ACC_P;
				uw.mul    = MUL_DCIN_DM;
				uw.rnd_en = 1'b1;
			end
			ST_INTEG: begin
				uw.alu    = ALU_INTEG;
				uw.mul    = MUL_DFB_D;
				uw.rnd_en = 1'b1;
			end
			ST_DTMP: begin
				uw.alu    = ALU_DTMP;
				uw.mul    = MUL_GI_I;
				uw.rnd_en = 1'b1;
			end
			ST_DERIV: begin
				uw.alu    = ALU_DERIV;
				uw.rnd_en = 1'b1;
			end
			ST_ACC_I: begin
				uw.alu = ALU_ACC_I;
				uw.mul = MUL_GD_D;
			end
			ST_RND_D:   uw.rnd_en = 1'b1;
			ST_FINISH: begin
				uw.alu  = ALU_FINISH;
				uw.last = 1'b1;
			end
			default:    uw.last = 1'b1;
		endcase
		return uw;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] sat_acc(
		input logic signed [ACC_W-1:0] v
	);
		if (v > ACC_MAX) begin
			return D_MAX;
		end else if (v < ACC_MIN) begin
			return D_MIN;
		end
		return v[DATA_WIDTH-1:0];
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] add_sat(
		input logic signed [DATA_WIDTH-1:0] a,
		input logic signed [DATA_WIDTH-1:0] b
	);
		return sat_acc(ACC_W'(a) + ACC_W'(b));
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] sub_sat(
		input logic signed [DATA_WIDTH-1:0] a,
		input logic signed [DATA_WIDTH-1:0] b
	);
		return sat_acc(ACC_W'(a) - ACC_W'(b));
	endfunction

	// Round half up at the chosen bit, shift arithmetically, then saturate.
	function automatic logic signed [DATA_WIDTH-1:0] rnd_sat(
		input logic signed [PROD_W-1:0] p,
		input logic                     wide
	);
		logic signed [PROD_W:0] s;
		logic signed [PROD_W:0] sh;
		s  = $signed({p[PROD_W-1], p}) + (wide ? RND_DEG : RND_FRAC);
		sh = wide ? (s >>> DEG_SHIFT) : (s >>> FRAC_BITS);
		if (sh > PW_MAX) begin
			return D_MAX;
		end else if (sh < PW_MIN) begin
			return D_MIN;
		end
		return sh[DATA_WIDTH-1:0];
	endfunction

endpackage

// ===== rtl/pi_d_controller_tustin_top.sv =====
// PI-D controller with Tustin integral and filtered derivative, microcoded datapath.
//
// Channel  Handshake               Payload
// in       in_valid / in_ready     setpoint, measured_now, measured_before
// out      out_valid / out_ready   control_action
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One beat of samples runs a 13-step program (11 steps with angle scaling off) on one
// shared 32x32 multiplier and its rounding stage; the input side stays busy until the
// program has finished, so a new beat is not taken while one is being worked on.
// The result sits in an output register, so a new beat is accepted while it waits.
// The last step stalls only while the previous result has not been taken by the consumer.
// Reset clears gains, coefficients and controller state; angle mode resets to on.
module pi_d_controller_tustin_top
	import pidt_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] setpoint,
	input  logic signed [DATA_WIDTH-1:0] measured_now,
	input  logic signed [DATA_WIDTH-1:0] measured_before,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] control_action,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [DATA_WIDTH-1:0]        cfg_data
);

	logic signed [DATA_WIDTH-1:0] gp_q, gi_q, gd_q, dcin_q, dfb_q;
	logic [DATA_WIDTH-2:0]        istep_q;
	logic                         angle_q, windup_q;
	logic signed [DATA_WIDTH-1:0] last_e_q, integ_q, deriv_q;

	logic                         busy_q;
	logic [STEP_W-1:0]            step_q;
	logic                         out_valid_q;

	logic signed [DATA_WIDTH-1:0] sp_q, mn_q, mb_q;
	logic signed [DATA_WIDTH-1:0] e_q, dm_q, esum_q, t_q, dtmp_q, out_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [ACC_W-1:0]      acc_q;

	uword_t                       uw;
	logic                         run;
	logic                         accept;
	logic                         hold_i;
	logic signed [MUL_W-1:0]      mul_a, mul_b;

	assign uw     = ucode(step_q);
	// The final step waits while the previous result has not been taken.
	assign run    = busy_q && !(uw.alu == ALU_FINISH && out_valid_q && !out_ready);
	assign accept = in_valid && !busy_q;

	assign in_ready       = !busy_q;
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign control_action = out_q;

	// Anti-windup drops the integral term on a negative error with a positive integral.
	assign hold_i = windup_q && e_q[DATA_WIDTH-1] && !integ_q[DATA_WIDTH-1] && (|integ_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (uw.mul)
			MUL_E_DEG: begin
				mul_a = MUL_W'(e_q);
				mul_b = DEG_TO_RAD;
			end
			MUL_GP_E: begin
				mul_a = MUL_W'(gp_q);
				mul_b = MUL_W'(e_q);
			end
			MUL_IS_ESUM: begin
				mul_a = MUL_W'($signed({1'b0, istep_q}));
				mul_b = MUL_W'(esum_q);
			end
			MUL_DCIN_DM: begin
				mul_a = MUL_W'(dcin_q);
				mul_b = MUL_W'(dm_q);
			end
			MUL_DFB_D: begin
				mul_a = MUL_W'(dfb_q);
				mul_b = MUL_W'(deriv_q);
			end
			MUL_GI_I: begin
				mul_a = MUL_W'(gi_q);
				mul_b = MUL_W'(integ_q);
			end
			MUL_GD_D: begin
				mul_a = MUL_W'(gd_q);
				mul_b = MUL_W'(deriv_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q        <= '0;
			gi_q        <= '0;
			gd_q        <= '0;
			istep_q     <= '0;
			dcin_q      <= '0;
			dfb_q       <= '0;
			angle_q     <= 1'b1;
			windup_q    <= 1'b0;
			last_e_q    <= '0;
			integ_q     <= '0;
			deriv_q     <= '0;
			busy_q      <= 1'b0;
			step_q      <= ST_DIFF;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_GAIN_P:              gp_q     <= $signed(cfg_data);
					REG_GAIN_I:              gi_q     <= $signed(cfg_data);
					REG_GAIN_D:              gd_q     <= $signed(cfg_data);
					REG_INTEGRAL_STEP:       istep_q  <= cfg_data[DATA_WIDTH-2:0];
					REG_DERIV_INPUT_COEF:    dcin_q   <= $signed(cfg_data);
					REG_DERIV_FEEDBACK_COEF: dfb_q    <= $signed(cfg_data);
					REG_ANGLE_MODE:          angle_q  <= cfg_data[0];
					REG_WINDUP_MODE:         windup_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (run) begin
				case (uw.alu)
					ALU_ESUM:  last_e_q <= e_q;
					ALU_INTEG: integ_q  <= add_sat(integ_q, t_q);
					ALU_DERIV: deriv_q  <= add_sat(dtmp_q, t_q);
					default: ;
				endcase
			end

			if (run && uw.alu == ALU_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				busy_q <= 1'b1;
				step_q <= ST_DIFF;
			end else if (run) begin
				if (uw.last) begin
					busy_q <= 1'b0;
				end else if (uw.br_nangle && !angle_q) begin
					step_q <= uw.target;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sp_q <= setpoint;
			mn_q <= measured_now;
			mb_q <= measured_before;
		end
		if (run) begin
			if (uw.mul != MUL_NONE) begin
				prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			end
			if (uw.rnd_en) begin
				t_q <= rnd_sat(prod_q, uw.rnd_wide);
			end
			case (uw.alu)
				ALU_DIFF: begin
					e_q  <= sub_sat(sp_q, mn_q);
					dm_q <= sub_sat(mn_q, mb_q);
				end
				ALU_E_RND:  e_q    <= t_q;
				ALU_ESUM:   esum_q <= add_sat(e_q, last_e_q);
				ALU_ACC_P:  acc_q  <= ACC_W'(t_q);
				ALU_DTMP:   dtmp_q <= t_q;
				ALU_ACC_I:  acc_q  <= acc_q + (hold_i ? ACC_W'(0) : ACC_W'(t_q));
				ALU_FINISH: out_q  <= sat_acc(acc_q - ACC_W'(t_q));
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/pidt_checker.sv =====
// Port-level checker of the PI-D controller and its bind to the top level.
`include "pi_d_controller_tustin_top_assert.svh"

module pidt_checker
	import pidt_pkg::*;
(
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [DATA_WIDTH-1:0] control_action
);

	// A held result keeps its value until the consumer takes the beat.
	`PIDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(control_action), "result changed while stalled")

	// Only one sample is worked on at a time.
	`PIDT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input accepted while busy")

	// A fresh result ends the program and frees the input side.
	`PIDT_ASSERT_SAME(a_result_ends_work, $rose(out_valid), in_ready && $past(!in_ready), "result without work")

	// The program cannot finish over a result that is still waiting.
	`PIDT_ASSERT_NEXT(a_no_overwrite, out_valid && !out_ready && !in_ready, !in_ready, "result overwritten")

endmodule

bind pi_d_controller_tustin_top pidt_checker u_pidt_checker (.*);
